### design/matrix_inverse_3x3_assert.svh
// Assertion macros shared by the checker of the 3x3 matrix inverse block.
`ifndef MATRIX_INVERSE_3X3_ASSERT_SVH
`define MATRIX_INVERSE_3X3_ASSERT_SVH
// Check a property while out of reset.
`define MI3_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("mi3 assertion failed");
// Check a property at every edge, reset included.
`define MI3_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mi3 reset assertion failed");
`endif

### design/mi3_pkg.sv
// Types, widths and constants of the 3x3 matrix inverse block.
`default_nettype none
package mi3_pkg;
    localparam int ENTRY_WIDTH  = 16;
    localparam int RESULT_WIDTH = 32;
    localparam int ENTRY_FRAC   = 12;
    localparam int RESULT_FRAC  = 16;
    localparam int SCALE        = ENTRY_FRAC + RESULT_FRAC;
    localparam int EW           = ENTRY_WIDTH;
    localparam int RW           = RESULT_WIDTH;
    localparam int COF_W        = 2 * EW + 1;
    localparam int DET_W        = EW + COF_W;
    localparam int MAG_W        = DET_W - 1;
    localparam int NUM_W        = COF_W - 1 + SCALE;
    localparam int QW           = RW + 1;
    localparam int NLANE        = 9;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);

    typedef logic signed [EW-1:0]    t_ent;
    typedef logic signed [COF_W-1:0] t_cof;
    typedef t_cof [NLANE-1:0]        t_adj;

    typedef struct packed {
        t_ent m_r0c0; t_ent m_r0c1; t_ent m_r0c2;
        t_ent m_r1c0; t_ent m_r1c1; t_ent m_r1c2;
        t_ent m_r2c0; t_ent m_r2c1; t_ent m_r2c2;
    } t_mat;

    typedef struct packed {
        logic signed [RW-1:0] inv_r0c0; logic signed [RW-1:0] inv_r0c1;
        logic signed [RW-1:0] inv_r0c2; logic signed [RW-1:0] inv_r1c0;
        logic signed [RW-1:0] inv_r1c1; logic signed [RW-1:0] inv_r1c2;
        logic signed [RW-1:0] inv_r2c0; logic signed [RW-1:0] inv_r2c1;
        logic signed [RW-1:0] inv_r2c2;
        logic singular;
        logic overflow;
    } t_res;

    typedef struct packed {
        t_adj adj;
        logic signed [DET_W-1:0] det;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;
endpackage
`default_nettype wire

### design/mi3_front.sv
// Front part: accepts matrices, forms cofactors and the determinant.
`default_nettype none
module mi3_front import mi3_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic push,
    output logic      full,
    input  t_mat      i_mat,
    input  t_qstat    i_qstat,
    output logic      o_qpush,
    output t_item     o_item
);
    typedef struct packed {
        t_ent e0; t_ent e1; t_ent e2;
        t_adj adj;
    } t_s1;

    logic  r_v1, r_v2, en;
    t_s1   r_s1, n_s1;
    t_item r_s2, n_s2;

    function automatic t_cof cof(input t_ent x, input t_ent w, input t_ent y, input t_ent z);
        logic signed [2*EW-1:0] p, q;
        p = x * w;
        q = y * z;
        return COF_W'(p) - COF_W'(q);
    endfunction

    assign en      = !(r_v2 && i_qstat.full);
    assign full    = !en;
    assign o_qpush = r_v2 && en;
    assign o_item  = r_s2;

    always_comb begin
        n_s1.e0     = i_mat.m_r0c0;
        n_s1.e1     = i_mat.m_r0c1;
        n_s1.e2     = i_mat.m_r0c2;
        n_s1.adj[0] = cof(i_mat.m_r1c1, i_mat.m_r2c2, i_mat.m_r1c2, i_mat.m_r2c1);
        n_s1.adj[1] = cof(i_mat.m_r0c2, i_mat.m_r2c1, i_mat.m_r0c1, i_mat.m_r2c2);
        n_s1.adj[2] = cof(i_mat.m_r0c1, i_mat.m_r1c2, i_mat.m_r0c2, i_mat.m_r1c1);
        n_s1.adj[3] = cof(i_mat.m_r1c2, i_mat.m_r2c0, i_mat.m_r1c0, i_mat.m_r2c2);
        n_s1.adj[4] = cof(i_mat.m_r0c0, i_mat.m_r2c2, i_mat.m_r0c2, i_mat.m_r2c0);
        n_s1.adj[5] = cof(i_mat.m_r0c2, i_mat.m_r1c0, i_mat.m_r0c0, i_mat.m_r1c2);
        n_s1.adj[6] = cof(i_mat.m_r1c0, i_mat.m_r2c1, i_mat.m_r1c1, i_mat.m_r2c0);
        n_s1.adj[7] = cof(i_mat.m_r0c1, i_mat.m_r2c0, i_mat.m_r0c0, i_mat.m_r2c1);
        n_s1.adj[8] = cof(i_mat.m_r0c0, i_mat.m_r1c1, i_mat.m_r0c1, i_mat.m_r1c0);
    end

    always_comb begin
        logic signed [DET_W-1:0]   p0, p1, p2;
        logic signed [DET_W+1:0]   s;
        p0 = r_s1.e0 * r_s1.adj[0];
        p1 = r_s1.e1 * r_s1.adj[3];
        p2 = r_s1.e2 * r_s1.adj[6];
        s  = (DET_W+2)'(p0) + (DET_W+2)'(p1) + (DET_W+2)'(p2);
        // exact determinant always fits DET_W bits
        n_s2.det = DET_W'(s);
        n_s2.adj = r_s1.adj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= push;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
    end
endmodule
`default_nettype wire

### design/mi3_queue.sv
// Short queue between the front and back parts.
`default_nettype none
module mi3_queue import mi3_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_item     i_item,
    input  wire logic i_pop,
    output t_item     o_item,
    output t_qstat    o_stat
);
    t_item                r_mem [QDEPTH];
    t_item                r_out;
    logic [QPTR_W-1:0]    r_wr, r_rd, n_rd;
    logic [QPTR_W:0]      r_cnt;
    logic                 do_push, do_pop;

    assign o_stat.full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign n_rd         = do_pop ? r_rd + 1'b1 : r_rd;
    assign o_item       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_item;
        // read the next head; take the incoming transaction when it lands there
        if (do_push && (r_wr == n_rd)) r_out <= i_item;
        else r_out <= r_mem[n_rd];
    end
endmodule
`default_nettype wire

### design/mi3_back.sv
// Back part: pipelined long division of the adjugate by the determinant.
`default_nettype none
module mi3_back import mi3_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_item     i_item,
    input  t_qstat    i_qstat,
    output logic      o_qpop,
    output logic      empty,
    input  wire logic pop,
    output t_res      o_res
);
    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [QW-1:0]    low;
        logic             neg;
        logic             big;
    } t_lane;

    typedef struct packed {
        logic             sing;
        logic [MAG_W-1:0] dmag;
        t_lane [NLANE-1:0] lane;
    } t_bst;

    logic              en, r_ov;
    logic [QW:0]       r_val;
    t_bst              r_st [QW+1];
    t_bst              n_prep;
    t_res              r_res, n_res;

    function automatic t_lane div_step(input t_lane a, input logic [MAG_W-1:0] d);
        t_lane            r;
        logic [MAG_W:0]   t;
        logic             ge;
        r  = a;
        t  = {a.rem, a.low[QW-1]};
        ge = (t >= {1'b0, d});
        r.rem = ge ? MAG_W'(t - {1'b0, d}) : MAG_W'(t);
        r.low = {a.low[QW-2:0], ge};
        return r;
    endfunction

    assign en     = !(r_ov && !pop);
    assign o_qpop = en && !i_qstat.empty;
    assign empty  = !r_ov;
    assign o_res  = r_res;

    always_comb begin
        logic                dneg;
        logic [DET_W-1:0]    dabs;
        logic [COF_W-1:0]    aabs;
        logic [COF_W-2:0]    cm;
        logic [NUM_W-1:0]    num;
        dneg        = i_item.det[DET_W-1];
        dabs        = dneg ? DET_W'(-i_item.det) : DET_W'(i_item.det);
        n_prep.sing = (i_item.det == '0);
        n_prep.dmag = dabs[MAG_W-1:0];
        for (int k = 0; k < NLANE; k++) begin
            aabs = i_item.adj[k][COF_W-1] ? COF_W'(-i_item.adj[k]) : COF_W'(i_item.adj[k]);
            cm   = aabs[COF_W-2:0];
            num  = {cm, {SCALE{1'b0}}};
            n_prep.lane[k].neg = i_item.adj[k][COF_W-1] ^ dneg;
            n_prep.lane[k].rem = MAG_W'(num[NUM_W-1:QW]);
            n_prep.lane[k].low = num[QW-1:0];
            // quotient of 2^QW or more cannot fit
            n_prep.lane[k].big = (MAG_W'(num[NUM_W-1:QW]) >= dabs[MAG_W-1:0]);
        end
    end

    always_comb begin
        logic [QW-1:0]        lim, q;
        logic                 sat, ovf;
        logic signed [RW-1:0] v [NLANE];
        ovf = 1'b0;
        for (int k = 0; k < NLANE; k++) begin
            lim = r_st[QW].lane[k].neg ? QW'(1) << (RW-1) : (QW'(1) << (RW-1)) - 1'b1;
            sat = r_st[QW].lane[k].big || (r_st[QW].lane[k].low > lim);
            q   = sat ? lim : r_st[QW].lane[k].low;
            ovf = ovf | sat;
            v[k] = r_st[QW].lane[k].neg ? RW'(-q) : RW'(q);
            if (r_st[QW].sing) v[k] = '0;
        end
        n_res.inv_r0c0 = v[0]; n_res.inv_r0c1 = v[1]; n_res.inv_r0c2 = v[2];
        n_res.inv_r1c0 = v[3]; n_res.inv_r1c1 = v[4]; n_res.inv_r1c2 = v[5];
        n_res.inv_r2c0 = v[6]; n_res.inv_r2c1 = v[7]; n_res.inv_r2c2 = v[8];
        n_res.singular = r_st[QW].sing;
        n_res.overflow = ovf && !r_st[QW].sing;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
            r_ov  <= 1'b0;
        end else if (en) begin
            r_val <= {r_val[QW-1:0], !i_qstat.empty};
            r_ov  <= r_val[QW];
        end
    end

    // advance every division stage together
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st[0] <= n_prep;
            for (int s = 0; s < QW; s++) begin
                r_st[s+1].sing <= r_st[s].sing;
                r_st[s+1].dmag <= r_st[s].dmag;
                for (int k = 0; k < NLANE; k++) begin
                    r_st[s+1].lane[k] <= div_step(r_st[s].lane[k], r_st[s].dmag);
                end
            end
            r_res <= n_res;
        end
    end
endmodule
`default_nettype wire

### design/matrix_inverse_3x3.sv
// Top level of the 3x3 matrix inverse block.
// Input channel: drive a Q4.12 matrix on i_mat with push high; a transaction
// completes at a clock edge where push is high and full is low.
// Result channel: while empty is low, o_res carries the oldest inverse in
// Q16.16 with singular and overflow flags; pop high at an edge takes it.
// Throughput: one matrix per cycle while full stays low. Path from input
// transaction to result shown, with no stall: two front stages (cofactors, determinant),
// one queue slot, a setup stage, 33 restoring-division stages (one quotient
// bit each, nine lanes in parallel) and the output register.
// The division pipeline sets the latency; each of its stages is one wide
// subtract and compare.
// When the receiver stalls the back pipeline holds; the four-entry queue
// absorbs front traffic, and full rises once it fills.
// Reset empties the pipelines and the queue; empty goes high, full low.
`default_nettype none
module matrix_inverse_3x3 import mi3_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic push,
    output logic      full,
    input  t_mat      i_mat,
    output logic      empty,
    input  wire logic pop,
    output t_res      o_res
);
    t_item  q_in, q_out;
    t_qstat q_stat;
    logic   q_push, q_pop;

    mi3_front u_front (
        .i_clk, .i_rst_n, .push, .full, .i_mat,
        .i_qstat(q_stat), .o_qpush(q_push), .o_item(q_in)
    );

    mi3_queue u_queue (
        .i_clk, .i_rst_n, .i_push(q_push), .i_item(q_in),
        .i_pop(q_pop), .o_item(q_out), .o_stat(q_stat)
    );

    mi3_back u_back (
        .i_clk, .i_rst_n, .i_item(q_out), .i_qstat(q_stat),
        .o_qpop(q_pop), .empty, .pop, .o_res
    );
endmodule
`default_nettype wire

### design/mi3_checker.sv
// Port-level checker for the 3x3 matrix inverse block, with its bind.
`default_nettype none
`include "matrix_inverse_3x3_assert.svh"
module mi3_checker import mi3_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic push,
    input wire logic full,
    input wire logic empty,
    input wire logic pop,
    input t_res      o_res
);
    `MI3_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> empty && !full)
    `MI3_ASSERT(a_stall_hold, i_clk, i_rst_n, !empty && !pop |=> !empty && $stable(o_res))
    `MI3_ASSERT(a_sing_no_ovf, i_clk, i_rst_n, !empty && o_res.singular |-> !o_res.overflow)
    `MI3_ASSERT(a_sing_zero, i_clk, i_rst_n, !empty && o_res.singular |-> o_res.inv_r0c0 == 0 && o_res.inv_r1c1 == 0 && o_res.inv_r2c2 == 0 && o_res.inv_r0c1 == 0 && o_res.inv_r1c2 == 0)
endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (.*);
`default_nettype wire

### tb/sv/matrix_inverse_3x3_test.sv
// Self-checking testbench for the 3x3 matrix inverse block with a fixed-point predictor.
`default_nettype none
module matrix_inverse_3x3_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mi3_pkg::*;

    localparam int  NUM_RANDOM = 850;
    localparam longint CYCLE_LIMIT = 400000;

    int errors = 0;

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    endtask

    // Exact inverse by adjugate: cofactors, determinant, then scaled truncating divide.
    function automatic t_res invert(input t_mat m);
        t_res r;
        logic signed [63:0]  e [9];
        logic signed [63:0]  adj [9];
        logic signed [127:0] det;
        logic [127:0] dmag, num, q;
        logic [63:0]  lim, lane_val;
        logic signed [RW-1:0] lanes [9];
        logic neg;
        logic ovf;
        e[0] = m.m_r0c0; e[1] = m.m_r0c1; e[2] = m.m_r0c2;
        e[3] = m.m_r1c0; e[4] = m.m_r1c1; e[5] = m.m_r1c2;
        e[6] = m.m_r2c0; e[7] = m.m_r2c1; e[8] = m.m_r2c2;
        adj[0] = e[4]*e[8] - e[5]*e[7];
        adj[1] = e[2]*e[7] - e[1]*e[8];
        adj[2] = e[1]*e[5] - e[2]*e[4];
        adj[3] = e[5]*e[6] - e[3]*e[8];
        adj[4] = e[0]*e[8] - e[2]*e[6];
        adj[5] = e[2]*e[3] - e[0]*e[5];
        adj[6] = e[3]*e[7] - e[4]*e[6];
        adj[7] = e[1]*e[6] - e[0]*e[7];
        adj[8] = e[0]*e[4] - e[1]*e[3];
        det = 128'(e[0]) * 128'(adj[0]) + 128'(e[1]) * 128'(adj[3])
            + 128'(e[2]) * 128'(adj[6]);
        r = '0;
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        dmag = det < 0 ? -det : det;
        ovf = 1'b0;
        for (int k = 0; k < 9; k++) begin
            neg = (adj[k] < 0) != (det < 0);
            num = (adj[k] < 0 ? 128'(-adj[k]) : 128'(adj[k])) << SCALE;
            q = num / dmag;
            lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
            if (q > 128'(lim)) begin
                q = 128'(lim);
                ovf = 1'b1;
            end
            lane_val = neg ? -q[63:0] : q[63:0];
            lanes[k] = lane_val[RW-1:0];
        end
        r.inv_r0c0 = lanes[0]; r.inv_r0c1 = lanes[1]; r.inv_r0c2 = lanes[2];
        r.inv_r1c0 = lanes[3]; r.inv_r1c1 = lanes[4]; r.inv_r1c2 = lanes[5];
        r.inv_r2c0 = lanes[6]; r.inv_r2c1 = lanes[7]; r.inv_r2c2 = lanes[8];
        r.overflow = ovf;
        return r;
    endfunction

    class inverse_scoreboard;
        t_res pending_inverses[$];
        int checked = 0;
        int singular_seen = 0;
        int overflow_seen = 0;

        function void note_matrix(t_mat m);
            pending_inverses.push_back(invert(m));
        endfunction

        task check_inverse(t_res got);
            t_res want;
            if (pending_inverses.size() == 0) begin
                report("unexpected result", 0, 0);
                return;
            end
            want = pending_inverses.pop_front();
            checked++;
            if (want.singular) singular_seen++;
            if (want.overflow) overflow_seen++;
            if (got.inv_r0c0 !== want.inv_r0c0) report("inv_r0c0", got.inv_r0c0, want.inv_r0c0);
            if (got.inv_r0c1 !== want.inv_r0c1) report("inv_r0c1", got.inv_r0c1, want.inv_r0c1);
            if (got.inv_r0c2 !== want.inv_r0c2) report("inv_r0c2", got.inv_r0c2, want.inv_r0c2);
            if (got.inv_r1c0 !== want.inv_r1c0) report("inv_r1c0", got.inv_r1c0, want.inv_r1c0);
            if (got.inv_r1c1 !== want.inv_r1c1) report("inv_r1c1", got.inv_r1c1, want.inv_r1c1);
            if (got.inv_r1c2 !== want.inv_r1c2) report("inv_r1c2", got.inv_r1c2, want.inv_r1c2);
            if (got.inv_r2c0 !== want.inv_r2c0) report("inv_r2c0", got.inv_r2c0, want.inv_r2c0);
            if (got.inv_r2c1 !== want.inv_r2c1) report("inv_r2c1", got.inv_r2c1, want.inv_r2c1);
            if (got.inv_r2c2 !== want.inv_r2c2) report("inv_r2c2", got.inv_r2c2, want.inv_r2c2);
            if (got.singular !== want.singular) report("singular", got.singular, want.singular);
            if (got.overflow !== want.overflow) report("overflow", got.overflow, want.overflow);
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    t_mat i_mat = '0;
    logic full, empty;
    t_res o_res;

    inverse_scoreboard board = new();
    bit   stim_done = 1'b0;
    bit   hold_off = 1'b0;
    longint cycles = 0;

    matrix_inverse_3x3 i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_mat(i_mat),
        .empty(empty), .pop(pop), .o_res(o_res)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_ent pick_entry();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return t_ent'($urandom_range(0, 8)) - 16'sd4;
            3: return 16'sh1000;
            default: return t_ent'($urandom);
        endcase
    endfunction

    function automatic t_mat pick_matrix();
        t_mat m;
        case ($urandom_range(0, 9))
            0: begin
                // dependent rows give a zero determinant
                m = {9{16'sh0}};
                m.m_r0c0 = pick_entry(); m.m_r0c1 = pick_entry(); m.m_r0c2 = pick_entry();
                m.m_r1c0 = pick_entry(); m.m_r1c1 = pick_entry(); m.m_r1c2 = pick_entry();
                m.m_r2c0 = m.m_r0c0; m.m_r2c1 = m.m_r0c1; m.m_r2c2 = m.m_r0c2;
            end
            1: begin
                m = '0;
                m.m_r0c0 = t_ent'($urandom_range(1, 4));
                m.m_r1c1 = t_ent'($urandom_range(1, 4));
                m.m_r2c2 = t_ent'($urandom_range(1, 4));
            end
            2: m = {pick_entry(), pick_entry(), pick_entry(), pick_entry(), pick_entry(),
                    pick_entry(), pick_entry(), pick_entry(), pick_entry()};
            default: m = t_mat'({$urandom, $urandom, $urandom, $urandom, 16'($urandom)});
        endcase
        return m;
    endfunction

    // Leaves push high after the transaction; the next call or the caller drops it.
    task automatic send_matrix(input t_mat m);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push  <= 1'b1;
        i_mat <= m;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        board.note_matrix(m);
    endtask

    // Receiver: random stalls, plus a long hold-off while the sender keeps pushing.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off || (gap > 0)) begin
                pop <= 1'b0;
                if (gap > 0) gap--;
            end else if (pop && !empty) begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
                pop <= (gap == 0);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) board.check_inverse(o_res);
    end

    initial begin
        t_mat m;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: identity, extremes, zero, singular, saturating cases
        send_matrix('{m_r0c0: 16'sh1000, m_r1c1: 16'sh1000, m_r2c2: 16'sh1000, default: '0});
        send_matrix('0);
        send_matrix({9{16'sh7fff}});
        send_matrix({9{16'sh8000}});
        send_matrix('{m_r0c0: 16'sh8000, m_r1c1: 16'sh8000, m_r2c2: 16'sh8000, default: '0});
        send_matrix('{m_r0c0: 16'sh7fff, m_r1c1: 16'sh7fff, m_r2c2: 16'sh7fff, default: '0});
        send_matrix('{m_r0c0: 16'sh0001, m_r1c1: 16'sh0001, m_r2c2: 16'sh0001, default: '0});
        send_matrix('{m_r0c0: 16'shffff, m_r1c1: 16'sh0001, m_r2c2: 16'sh0001, default: '0});
        send_matrix('{m_r0c2: 16'sh1000, m_r1c1: 16'shf000, m_r2c0: 16'sh2000, default: '0});
        send_matrix('{m_r0c0: 16'sh0001, m_r0c1: 16'sh7fff, m_r1c1: 16'sh0001,
                      m_r2c2: 16'sh0001, default: '0});
        send_matrix({16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                     16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
        send_matrix({16'sh5555, 16'shaaaa, 16'sh0f0f, 16'shf0f0, 16'sh3333,
                     16'shcccc, 16'sh00ff, 16'shff00, 16'sh1234});
        send_matrix({16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0000, 16'sh8000,
                     16'sh7fff, 16'sh7fff, 16'sh0000, 16'sh8000});
        // long hold-off so the queue fills and full rises
        fork
            begin
                hold_off = 1'b1;
                repeat (80) @(posedge i_clk);
                hold_off = 1'b0;
            end
            repeat (60) begin
                m = pick_matrix();
                push  <= 1'b1;
                i_mat <= m;
                @(posedge i_clk);
                while (full) @(posedge i_clk);
                board.note_matrix(m);
            end
        join
        for (int n = 0; n < NUM_RANDOM; n++) send_matrix(pick_matrix());
        push <= 1'b0;
        while (board.pending_inverses.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Checked %0d inverses, %0d singular and %0d saturated.",
                 board.checked, board.singular_seen, board.overflow_seen);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
